### rtl/core/bdq_pkg.sv
// bdq_pkg: shared types, sizes and ring-index helpers for the bounded deque
// used by bdq_store, bdq_ctrl and bounded_deque_with_value_delete
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // ring geometry
  localparam int DEPTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // beat payload widths
  localparam int FUNC_W     = 4;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 6;
  localparam int IN_TDATA_W = ((FUNC_W + WORD_W + COUNT_W + 7) / 8) * 8;
  localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT  = 4'd0,
    FN_ADD_BACK   = 4'd1,
    FN_DROP_FRONT = 4'd2,
    FN_DROP_BACK  = 4'd3,
    FN_CLEAR      = 4'd4,
    FN_DELETE     = 4'd5,
    FN_READ_ALL   = 4'd6,
    FN_READ_FIRST = 4'd7,
    FN_READ_LAST  = 4'd8
  } func_t;

  // single-port-write, single-port-read request to the entry store
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [WORD_W-1:0] wdata;
    logic                     re;
    logic [ADDR_W-1:0]        raddr;
  } mem_req_t;

  // result beat announced by the sequencer, data follows from the store
  typedef struct packed {
    logic valid;
    logic status;
    logic last;
  } push_t;

  // one buffered result beat
  typedef struct packed {
    logic signed [WORD_W-1:0] element;
    logic                     status;
    logic                     last;
  } out_beat_t;

  // ring slot at offset off from base, off no larger than DEPTH
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // next ring slot
  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
  endfunction

  // requested count clipped to the occupancy
  function automatic logic [CNT_W-1:0] clip_count(input logic [COUNT_W-1:0] c,
                                                  input logic [CNT_W-1:0]   occ);
    return (CMP_W'(c) < CMP_W'(occ)) ? CNT_W'(c) : occ;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bdq_store.sv
// bdq_store: ring memory of deque entries, one write and one registered read
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_store import bdq_pkg::*; (
  input  wire logic                     clk,
  input  wire mem_req_t                 req,
  output logic signed [WORD_W-1:0]      rd_data_r
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/bdq_ctrl.sv
// bdq_ctrl: command sequencer, ring pointers and the shared compare / index unit
// depends on bdq_pkg; drives bdq_store and announces result beats
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic [COUNT_W-1:0]       in_count,
  input  wire logic                     out_space,
  input  wire logic signed [WORD_W-1:0] rd_data,
  output mem_req_t                      mem_req,
  output push_t                         push_r
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FULL,
    S_EMIT,
    S_DEL
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]         occ_r, occ_nxt;
  logic [ADDR_W-1:0]        rptr_r, rptr_nxt;
  logic [ADDR_W-1:0]        wptr_r, wptr_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         kept_r, kept_nxt;
  logic                     dv_r, dv_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  push_t                    push_nxt;
  logic                     keep;
  logic [CNT_W-1:0]         n_clip;
  logic [CNT_W-1:0]         n_sel;
  logic [CNT_W-1:0]         start;

  assign in_ready = (state_r == S_IDLE);

  // shared compare: stored word survives the delete
  assign keep   = (rd_data != value_r);
  assign n_clip = clip_count(in_count, occ_r);

  // read-out length and start offset
  always_comb begin
    n_sel = occ_r;
    start = '0;
    if (in_func == FN_READ_FIRST) begin
      n_sel = n_clip;
    end else if (in_func == FN_READ_LAST) begin
      n_sel = n_clip;
      start = occ_r - n_clip;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    occ_nxt   = occ_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    rem_nxt   = rem_r;
    kept_nxt  = kept_r;
    dv_nxt    = 1'b0;
    value_nxt = value_r;
    push_nxt  = '0;
    mem_req   = '{we: 1'b0, waddr: wptr_r, wdata: rd_data, re: 1'b0, raddr: rptr_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt = in_value;
          unique case (in_func)
            FN_ADD_FRONT: begin
              if (occ_r == CNT_W'(DEPTH)) begin
                state_nxt = S_FULL;
              end else begin
                front_nxt     = slot_of(front_r, CNT_W'(DEPTH - 1));
                mem_req.we    = 1'b1;
                mem_req.waddr = front_nxt;
                mem_req.wdata = in_value;
                occ_nxt       = occ_r + CNT_W'(1);
              end
            end
            FN_ADD_BACK: begin
              if (occ_r == CNT_W'(DEPTH)) begin
                state_nxt = S_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_of(front_r, occ_r);
                mem_req.wdata = in_value;
                occ_nxt       = occ_r + CNT_W'(1);
              end
            end
            FN_DROP_FRONT: begin
              if (occ_r != '0) begin
                front_nxt = slot_inc(front_r);
                occ_nxt   = occ_r - CNT_W'(1);
              end
            end
            FN_DROP_BACK: begin
              if (occ_r != '0) begin
                occ_nxt = occ_r - CNT_W'(1);
              end
            end
            FN_CLEAR: begin
              occ_nxt   = '0;
              front_nxt = '0;
            end
            FN_DELETE: begin
              if (occ_r != '0) begin
                rptr_nxt  = front_r;
                wptr_nxt  = front_r;
                rem_nxt   = occ_r;
                kept_nxt  = '0;
                state_nxt = S_DEL;
              end
            end
            FN_READ_ALL, FN_READ_FIRST, FN_READ_LAST: begin
              rptr_nxt = slot_of(front_r, start);
              rem_nxt  = n_sel;
              if (n_sel != '0) begin
                state_nxt = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // dropped add: one status beat once the output has room
      S_FULL: begin
        if (out_space) begin
          push_nxt  = '{valid: 1'b1, status: 1'b1, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end

      // read-out: one entry per cycle while the output has room
      S_EMIT: begin
        if (out_space) begin
          mem_req.re = 1'b1;
          push_nxt   = '{valid: 1'b1, status: 1'b0, last: (rem_r == CNT_W'(1))};
          rptr_nxt   = slot_inc(rptr_r);
          rem_nxt    = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // value delete: read ahead, compare, compact survivors toward the front
      S_DEL: begin
        if (dv_r && keep) begin
          mem_req.we = 1'b1;
          wptr_nxt   = slot_inc(wptr_r);
          kept_nxt   = kept_r + CNT_W'(1);
        end
        if (rem_r != '0) begin
          mem_req.re = 1'b1;
          rptr_nxt   = slot_inc(rptr_r);
          rem_nxt    = rem_r - CNT_W'(1);
          dv_nxt     = 1'b1;
        end else if (dv_r) begin
          occ_nxt   = kept_nxt;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rptr_r  <= rptr_nxt;
    wptr_r  <= wptr_nxt;
    rem_r   <= rem_nxt;
    kept_r  <= kept_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
      dv_r    <= 1'b0;
      push_r  <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      dv_r    <= dv_nxt;
      push_r  <= push_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a result beat is only announced when the output buffer had room
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_r.valid |-> $past(out_space))
    else $error("result beat announced without output room");

  // compaction never keeps more entries than it started with
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL) |-> (kept_r <= occ_r))
    else $error("delete kept more entries than stored");

  // compaction write never collides with the read-ahead slot
  a_del_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL && mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("delete write hit the read-ahead slot");

  // a read-out in progress always has entries left
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (rem_r != '0))
    else $error("read-out running with nothing left");
`endif

endmodule

`default_nettype wire

### rtl/core/bounded_deque_with_value_delete.sv
// Bounded double-ended queue of signed 32-bit words with value delete.
// Input channel (in_*): one command beat per item; func, value and count are
// packed in in_tdata. Result channel (out_*): out_tdata carries the entry read
// out (zero on a status beat), out_tuser flags a dropped add on a full list,
// out_tlast marks the final beat of a command.
// Pacing: add, drop and clear complete while the block stays idle. A read-out
// first loads its read pointer and then gives one beat per cycle while the
// result buffer has room; the single read port of the entry store sets that
// pace. A value delete walks the occupied entries through the same port and
// one comparator. A dropped add waits for buffer room to send its status beat.
// in_tready is low while a command is in progress.
// The result side has a two-beat buffer; the sequencer only issues a beat
// when the buffer has room, so a stalled receiver holds the block in its
// current command without losing beats. A new command is taken while earlier
// result beats still wait in the buffer.
// Reset (rst_n low, synchronous) empties the list and the result buffer; the
// entry store needs no clearing pass.
// Depends on bdq_pkg, bdq_store and bdq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_delete import bdq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // func[3:0], value[35:4], count[41:36]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [WORD_W-1:0]          out_tdata,  // element[31:0]
  output logic                       out_tuser,  // status[0]
  output logic                       out_tlast
);

  mem_req_t                 mem_req;
  push_t                    push;
  logic signed [WORD_W-1:0] rd_data;
  logic                     out_space;
  logic                     pop;
  logic [2:0]               level;
  out_beat_t                beat_in;
  logic [1:0]               cnt_r, cnt_nxt;
  out_beat_t                slot0_r, slot0_nxt;
  out_beat_t                slot1_r, slot1_nxt;

  bdq_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_data)
  );

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tdata[FUNC_W-1:0]),
    .in_value  (in_tdata[FUNC_W+WORD_W-1:FUNC_W]),
    .in_count  (in_tdata[FUNC_W+WORD_W+COUNT_W-1:FUNC_W+WORD_W]),
    .out_space (out_space),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .push_r    (push)
  );

  // incoming result beat: store data, forced to zero on a status beat
  assign beat_in = '{element: (push.status ? '0 : rd_data),
                     status:  push.status,
                     last:    push.last};

  assign pop       = out_tvalid && out_tready;
  assign level     = 3'(cnt_r) + 3'(push.valid) - 3'(pop);
  assign out_space = (level < 3'd2);

  // two-beat result buffer
  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    unique case (cnt_r)
      2'd0: begin
        if (push.valid) begin
          slot0_nxt = beat_in;
          cnt_nxt   = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push.valid) begin
          slot0_nxt = beat_in;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end else if (push.valid) begin
          slot1_nxt = beat_in;
          cnt_nxt   = 2'd2;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_nxt = slot1_r;
          if (push.valid) begin
            slot1_nxt = beat_in;
          end else begin
            cnt_nxt = 2'd1;
          end
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result port
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot0_r.element;
  assign out_tuser  = slot0_r.status;
  assign out_tlast  = slot0_r.last;

endmodule

`default_nettype wire

### bench/tb_bounded_deque_with_value_delete.sv
// testbench for bounded_deque_with_value_delete: random and directed command beats,
// with a tracking copy of the deque that predicts every result beat
// depends on bdq_pkg and the rtl of bounded_deque_with_value_delete
`timescale 1ns / 1ps

module tb_bounded_deque_with_value_delete import bdq_pkg::*;;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = DEPTH + 8;

  // command codes the block ignores
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  // shadow deque plus the beats it still owes
  class deque_tracker;
    logic signed [WORD_W-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned fill;
    out_beat_t   pending_beats[$];
    int          errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pos_to_slot(int unsigned pos);
      return (head + pos) % DEPTH;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // read-out beats for n entries from list position start, front to back
    function void owe_span(int unsigned start, int unsigned n);
      out_beat_t b;
      for (int unsigned i = 0; i < n; i++) begin
        b.element = ring[pos_to_slot(start + i)];
        b.status  = 1'b0;
        b.last    = (i + 1 == n);
        pending_beats.push_back(b);
      end
    endfunction

    // update the shadow deque for one accepted command beat
    function void apply_command(logic [FUNC_W-1:0] fn, logic signed [WORD_W-1:0] val,
                                logic [COUNT_W-1:0] cnt);
      out_beat_t                b;
      int unsigned              kept;
      int unsigned              n;
      logic signed [WORD_W-1:0] w;
      n = (cnt < fill) ? cnt : fill;
      case (fn)
        FN_ADD_FRONT, FN_ADD_BACK: begin
          if (fill >= DEPTH) begin
            // full list: add dropped, one status beat
            b.element = '0;
            b.status  = 1'b1;
            b.last    = 1'b1;
            pending_beats.push_back(b);
          end else if (fn == FN_ADD_FRONT) begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = val;
            fill++;
          end else begin
            ring[pos_to_slot(fill)] = val;
            fill++;
          end
        end
        FN_DROP_FRONT: begin
          if (fill != 0) begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        FN_DROP_BACK: begin
          if (fill != 0) fill--;
        end
        FN_CLEAR: begin
          fill = 0;
          head = 0;
        end
        FN_DELETE: begin
          // survivors keep their order, packed toward the front
          kept = 0;
          for (int unsigned i = 0; i < fill; i++) begin
            w = ring[pos_to_slot(i)];
            if (w != val) begin
              ring[pos_to_slot(kept)] = w;
              kept++;
            end
          end
          fill = kept;
        end
        FN_READ_ALL:   owe_span(0, fill);
        FN_READ_FIRST: owe_span(0, n);
        FN_READ_LAST:  owe_span(fill - n, n);
        default: ;
      endcase
    endfunction

    // compare one accepted result beat with the oldest owed beat
    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_beats.size() == 0) begin
        note_error($sformatf("unexpected beat: element %0d status %0b last %0b",
                             got.element, got.status, got.last));
        return;
      end
      want = pending_beats.pop_front();
      if (want.element !== got.element || want.status !== got.status ||
          want.last !== got.last) begin
        note_error($sformatf({"beat mismatch: expected element %0d status %0b last %0b,",
                              " got element %0d status %0b last %0b"},
                             want.element, want.status, want.last,
                             got.element, got.status, got.last));
      end
    endfunction

    function void flush();
      if (pending_beats.size() != 0)
        note_error($sformatf("%0d expected beats never arrived", pending_beats.size()));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // func[3:0], value[35:4], count[41:36]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [WORD_W-1:0]     out_tdata;  // element[31:0]
  logic                  out_tuser;  // status[0]
  logic                  out_tlast;

  deque_tracker tracker;
  int unsigned  commands_sent;
  int unsigned  cycle_count = 0;
  logic         steady_phase = 1'b0;

  bounded_deque_with_value_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result beat monitor
  always @(posedge clk) begin
    out_beat_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.element = out_tdata;
      seen.status  = out_tuser;
      seen.last    = out_tlast;
      tracker.check_beat(seen);
    end
  end

  // receiver: random stall before each beat
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady_phase ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // one command beat; entered and left at a falling edge
  task automatic send_command(input logic [FUNC_W-1:0] fn, input logic signed [WORD_W-1:0] val,
                              input logic [COUNT_W-1:0] cnt);
    int unsigned gap;
    gap = steady_phase ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - FUNC_W - WORD_W - COUNT_W){1'b0}}, cnt, val, fn};
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.apply_command(fn, val, cnt);
    if (fn <= FN_READ_LAST) commands_sent++;
    @(negedge clk);
  endtask

  // small repeating values so deletes find duplicates, plus extremes and noise
  function automatic logic signed [WORD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 3) return WORD_W'($urandom_range(0, 3));
    if (r == 3) return {1'b0, {(WORD_W - 1){1'b1}}};
    if (r == 4) return {1'b1, {(WORD_W - 1){1'b0}}};
    return $urandom;
  endfunction

  // a value currently held, when there is one
  function automatic logic signed [WORD_W-1:0] pick_present();
    if (tracker.fill == 0) return pick_value();
    return tracker.ring[tracker.pos_to_slot($urandom_range(0, tracker.fill - 1))];
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return COUNT_W'(DEPTH);
    return COUNT_W'($urandom_range(1, DEPTH));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_add();
    return $urandom_range(0, 1) ? FN_ADD_BACK : FN_ADD_FRONT;
  endfunction

  // grow to full, push against the full list, then read and delete
  task automatic run_fill_phase();
    while (tracker.fill < DEPTH) send_command(pick_add(), pick_value(), COUNT_W'($urandom));
    repeat ($urandom_range(1, 3)) send_command(pick_add(), pick_value(), COUNT_W'($urandom));
    send_command(FN_READ_ALL, $urandom, COUNT_W'($urandom));
    send_command(FN_READ_FIRST, $urandom, pick_count());
    send_command(FN_READ_LAST, $urandom, pick_count());
    send_command(FN_DELETE, pick_present(), COUNT_W'($urandom));
    send_command(FN_READ_ALL, $urandom, COUNT_W'($urandom));
  endtask

  // weighted mix of every command
  task automatic run_mixed_phase();
    int unsigned r;
    repeat (30) begin
      r = $urandom_range(0, 99);
      if (r < 22)      send_command(FN_ADD_FRONT, pick_value(), COUNT_W'($urandom));
      else if (r < 44) send_command(FN_ADD_BACK, pick_value(), COUNT_W'($urandom));
      else if (r < 52) send_command(FN_DROP_FRONT, $urandom, COUNT_W'($urandom));
      else if (r < 60) send_command(FN_DROP_BACK, $urandom, COUNT_W'($urandom));
      else if (r < 63) send_command(FN_CLEAR, $urandom, COUNT_W'($urandom));
      else if (r < 71)
        send_command(FN_DELETE, ($urandom_range(0, 9) < 7) ? pick_present() : pick_value(),
                     COUNT_W'($urandom));
      else if (r < 79) send_command(FN_READ_ALL, $urandom, COUNT_W'($urandom));
      else if (r < 88) send_command(FN_READ_FIRST, $urandom, pick_count());
      else if (r < 97) send_command(FN_READ_LAST, $urandom, pick_count());
      else send_command(FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)), $urandom,
                        COUNT_W'($urandom));
    end
  endtask

  // remove from both ends until empty, then a few removals on the empty list
  task automatic run_drain_phase();
    repeat (tracker.fill + $urandom_range(1, 3))
      send_command($urandom_range(0, 1) ? FN_DROP_BACK : FN_DROP_FRONT, $urandom,
                   COUNT_W'($urandom));
    send_command(FN_READ_ALL, $urandom, COUNT_W'($urandom));
  endtask

  initial begin
    int unsigned r;
    tracker   = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extremes, count edges, delete with compaction
    send_command(FN_READ_ALL, 32'sd0, 6'd0);
    send_command(FN_READ_FIRST, 32'sd0, 6'd5);
    send_command(FN_READ_LAST, 32'sd0, 6'd5);
    send_command(FN_DROP_FRONT, 32'sd0, 6'd0);
    send_command(FN_DROP_BACK, 32'sd0, 6'd0);
    send_command(FN_DELETE, 32'sd0, 6'd0);
    send_command(FN_ADD_FRONT, 32'sh7fffffff, 6'd0);
    send_command(FN_ADD_BACK, 32'sh80000000, 6'd63);
    send_command(FN_ADD_FRONT, 32'sd0, 6'd0);
    send_command(FN_ADD_BACK, -32'sd1, 6'd0);
    send_command(FN_ADD_FRONT, 32'sh7fffffff, 6'd0);
    send_command(FN_READ_ALL, 32'sd0, 6'd0);
    send_command(FN_READ_FIRST, 32'sd0, 6'd0);
    send_command(FN_READ_FIRST, 32'sd0, 6'd32);
    send_command(FN_READ_FIRST, 32'sd0, 6'd2);
    send_command(FN_READ_LAST, 32'sd0, 6'd0);
    send_command(FN_READ_LAST, 32'sd0, 6'd32);
    send_command(FN_READ_LAST, 32'sd0, 6'd1);
    send_command(FN_DELETE, 32'sh7fffffff, 6'd0);
    send_command(FN_READ_ALL, 32'sd0, 6'd0);
    send_command(FN_DROP_FRONT, 32'sd0, 6'd0);
    send_command(FN_DROP_BACK, 32'sd0, 6'd0);
    send_command(FN_READ_ALL, 32'sd0, 6'd0);
    send_command(FN_UNUSED_LO, -32'sd1, 6'd63);
    send_command(FN_UNUSED_HI, -32'sd1, 6'd63);
    send_command(FN_CLEAR, 32'sd0, 6'd0);
    send_command(FN_READ_ALL, 32'sd0, 6'd0);

    // random phases, the first one always reaching a full list
    run_fill_phase();
    while (commands_sent < RANDOM_ITEMS) begin
      steady_phase = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30)      run_fill_phase();
      else if (r < 85) run_mixed_phase();
      else             run_drain_phase();
    end
    steady_phase = 1'b0;
    in_tvalid <= 1'b0;

    // let owed beats arrive, then give the block time to go quiet
    while (tracker.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.flush();
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_store.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque_with_value_delete.sv
bench/tb_bounded_deque_with_value_delete.sv
